@@ hdl/montgomery_modular_exponentiation_defines.svh @@
// Assertion macros shared by the modular exponentiation design.
`ifndef MONTGOMERY_MODULAR_EXPONENTIATION_DEFINES_SVH
`define MONTGOMERY_MODULAR_EXPONENTIATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MME_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/mme_pkg.sv @@
// Shared types and constants of the modular exponentiation block.
`default_nettype none
package mme_pkg;

   localparam int WORD_BITS = 32;
   localparam int DEFAULT_MAX_WORDS = 32;

   typedef logic [WORD_BITS-1:0] word_type;

   localparam logic [1:0] CMD_LOAD_MOD  = 2'd0;
   localparam logic [1:0] CMD_LOAD_BASE = 2'd1;
   localparam logic [1:0] CMD_LOAD_EXP  = 2'd2;
   localparam logic [1:0] CMD_START     = 2'd3;

   localparam logic CSR_MOD_WORDS = 1'b0;
   localparam logic CSR_EXP_WORDS = 1'b1;

   // Word counts after clamping; never above 32.
   typedef struct packed {
      logic [5:0] k;
      logic [5:0] e;
   } words_cfg_type;

endpackage
`default_nettype wire

@@ hdl/montgomery_modular_exponentiation.sv @@
// Each load word is written as it is taken, so loads can come back to back. A start
// (k modulus words, e exponent words) runs the R^2 doubling sweep word by word, then
// the Montgomery products go word by word through one shared 32x32 multiplier.
// Each result word is read out and held until the sink takes it, then the next is read.
// Synchronous active-high reset clears the sequencer and sets both word counts to 32;
// the word stores hold their contents until written.
`default_nettype none
`include "montgomery_modular_exponentiation_defines.svh"
module montgomery_modular_exponentiation #(
   parameter int MAX_WORDS = mme_pkg::DEFAULT_MAX_WORDS
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [5:0]  csr_wdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // word_index[4:0], word_value[36:5]
   input  wire  [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // result_word[31:0], result_index[36:32]
   output logic        rsp_tlast
);
   localparam int WORD_LIMIT = (MAX_WORDS < 32) ? MAX_WORDS : 32;

   logic [5:0] mod_words_ff, mod_words_in, exp_words_ff, exp_words_in;
   mme_pkg::words_cfg_type cfg;

   always_comb begin
      mod_words_in = mod_words_ff;
      exp_words_in = exp_words_ff;
      if (csr_we) begin
         if (csr_index == mme_pkg::CSR_MOD_WORDS) begin
            mod_words_in = csr_wdata;
         end else begin
            exp_words_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_words_ff <= 6'd32;
         exp_words_ff <= 6'd32;
      end else begin
         mod_words_ff <= mod_words_in;
         exp_words_ff <= exp_words_in;
      end
   end

   // A count of zero acts as one; counts above MAX_WORDS or 32, whichever is smaller, saturate to it.
   always_comb begin
      cfg.k = mod_words_ff;
      cfg.e = exp_words_ff;
      if (mod_words_ff == 6'd0) begin
         cfg.k = 6'd1;
      end else if (32'(mod_words_ff) > WORD_LIMIT) begin
         cfg.k = 6'(WORD_LIMIT);
      end
      if (exp_words_ff == 6'd0) begin
         cfg.e = 6'd1;
      end else if (32'(exp_words_ff) > WORD_LIMIT) begin
         cfg.e = 6'(WORD_LIMIT);
      end
   end

   mme_core #(
      .MAX_WORDS (MAX_WORDS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `MME_ASSERT_SAME(a_no_req_during_rsp, rsp_tvalid, !req_tready,
      "request taken while a result is pending")
   `MME_ASSERT_NEXT(a_start_goes_busy,
      req_tvalid && req_tready && req_tuser == mme_pkg::CMD_START, !req_tready,
      "still ready after a start transfer")
   `MME_ASSERT_NEXT(a_load_stays_ready,
      req_tvalid && req_tready && req_tuser != mme_pkg::CMD_START, req_tready,
      "load transfer left the block busy")
   `MME_ASSERT_NEXT(a_idle_after_last, rsp_tvalid && rsp_tready && rsp_tlast,
      req_tready && !rsp_tvalid, "block not idle after the final result transfer")
endmodule
`default_nettype wire

@@ hdl/mme_mac.sv @@
// Shared 32x32 multiply with two 32-bit addends.
`default_nettype none
module mme_mac (
   input  wire mme_pkg::word_type x,
   input  wire mme_pkg::word_type y,
   input  wire mme_pkg::word_type a,
   input  wire mme_pkg::word_type c,
   output mme_pkg::word_type      hi,
   output mme_pkg::word_type      lo
);
   logic [2*mme_pkg::WORD_BITS-1:0] full;

   // The sum never exceeds 2^64 - 1, so no bit is lost.
   assign full = 64'(x) * 64'(y) + 64'(a) + 64'(c);
   assign hi = full[63:32];
   assign lo = full[31:0];
endmodule
`default_nettype wire

@@ hdl/mme_core.sv @@
// Word stores and the sequencer that drives the shared multiply unit.
`default_nettype none
module mme_core #(
   parameter int MAX_WORDS = mme_pkg::DEFAULT_MAX_WORDS
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire mme_pkg::words_cfg_type cfg,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire [39:0]                 req_tdata,   // word_index[4:0], word_value[36:5]
   input  wire [1:0]                  req_tuser,   // command[1:0]
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [39:0]                rsp_tdata,   // result_word[31:0], result_index[36:32]
   output logic                       rsp_tlast
);
   localparam int DEPTH = MAX_WORDS + 2;
   localparam int AW = $clog2(DEPTH);
   localparam int WORD_LIMIT = (MAX_WORDS < 32) ? MAX_WORDS : 32;
   localparam int CW = $clog2(64 * WORD_LIMIT);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_INV_RD   = 5'd1;
   localparam logic [4:0] S_INV_A    = 5'd2;
   localparam logic [4:0] S_INV_B    = 5'd3;
   localparam logic [4:0] S_R_CLR    = 5'd4;
   localparam logic [4:0] S_DBL      = 5'd5;
   localparam logic [4:0] S_RSUB     = 5'd6;
   localparam logic [4:0] S_MM_INIT  = 5'd7;
   localparam logic [4:0] S_MM_B     = 5'd8;
   localparam logic [4:0] S_MM_A1    = 5'd9;
   localparam logic [4:0] S_MM_Q     = 5'd10;
   localparam logic [4:0] S_MM_A2    = 5'd11;
   localparam logic [4:0] S_MM_TOP   = 5'd12;
   localparam logic [4:0] S_MM_GE    = 5'd13;
   localparam logic [4:0] S_MM_OUT   = 5'd14;
   localparam logic [4:0] S_EXP_RD   = 5'd15;
   localparam logic [4:0] S_OUT_RD   = 5'd16;
   localparam logic [4:0] S_OUT_WAIT = 5'd17;

   localparam logic [2:0] OP_ONE_R = 3'd0;
   localparam logic [2:0] OP_BASE_R = 3'd1;
   localparam logic [2:0] OP_SQ    = 3'd2;
   localparam logic [2:0] OP_MUL   = 3'd3;
   localparam logic [2:0] OP_FIN   = 3'd4;

   mme_pkg::word_type mod_mem_ff   [DEPTH];
   mme_pkg::word_type base_mem_ff  [DEPTH];
   mme_pkg::word_type exp_mem_ff   [DEPTH];
   mme_pkg::word_type mbase_mem_ff [DEPTH];
   mme_pkg::word_type acc_mem_ff   [DEPTH];
   mme_pkg::word_type rsq_mem_ff   [DEPTH];
   mme_pkg::word_type prod_mem_ff  [DEPTH];

   mme_pkg::word_type rd_mod_ff, rd_base_ff, rd_exp_ff, rd_mbase_ff;
   mme_pkg::word_type rd_acc_ff, rd_rsq_ff, rd_prod_ff;

   logic [4:0]        state_ff, state_in;
   logic              ph_ff, ph_in;
   logic [AW-1:0]     j_ff, j_in, i_ff, i_in, ew_ff, ew_in;
   logic [4:0]        bit_ff, bit_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [1:0]        it_ff, it_in;
   logic [2:0]        op_ff, op_in;
   mme_pkg::word_type n0_ff, n0_in, inv_ff, inv_in, tmp_ff, tmp_in, neg_ff, neg_in;
   mme_pkg::word_type s_ff, s_in, carry_ff, carry_in, ewd_ff, ewd_in;
   logic              borrow_ff, borrow_in, ge_ff, ge_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   mme_pkg::word_type rsp_word_ff, rsp_word_in;
   logic [4:0]        rsp_idx_ff, rsp_idx_in;

   logic [AW-1:0]     raddr, wa, k_w, e_w, kp1, km1;
   mme_pkg::word_type wd, nv, aword, bword, sub_x, dbl_word, mac_x, mac_y, mac_a, mac_c;
   mme_pkg::word_type mac_hi, mac_lo;
   logic [32:0]       sub_ext;
   logic              we_mod, we_base, we_exp, we_mbase, we_acc, we_rsq, we_prod;
   logic              idx_ok, adv;
   logic [4:0]        ld_idx;
   logic [CW-1:0]     dbl_end;

   mme_mac u_mac (
      .x  (mac_x),
      .y  (mac_y),
      .a  (mac_a),
      .c  (mac_c),
      .hi (mac_hi),
      .lo (mac_lo)
   );

   assign k_w = AW'(cfg.k);
   assign e_w = AW'(cfg.e);
   assign kp1 = k_w + AW'(1);
   assign km1 = k_w - AW'(1);
   assign dbl_end = CW'({k_w, 6'b0}) - CW'(1);
   assign ld_idx = req_tdata[4:0];
   assign idx_ok = 32'(ld_idx) < MAX_WORDS;

   assign raddr = (state_ff == S_MM_B) ? i_ff : ((state_ff == S_EXP_RD) ? ew_ff : j_ff);

   // Modulus words at or above k read as zero.
   assign nv = (j_ff < k_w) ? rd_mod_ff : '0;
   assign dbl_word = {rd_rsq_ff[30:0], carry_ff[0]};

   always_comb begin
      case (op_ff)
         OP_ONE_R:  aword = (j_ff == '0) ? 32'd1 : 32'd0;
         OP_BASE_R: aword = rd_base_ff;
         default:   aword = rd_prod_ff;
      endcase
      if (j_ff >= k_w) begin
         aword = '0;
      end
      case (op_ff)
         OP_ONE_R, OP_BASE_R: bword = rd_rsq_ff;
         OP_SQ:               bword = rd_prod_ff;
         OP_MUL:              bword = rd_mbase_ff;
         default:             bword = (i_ff == '0) ? 32'd1 : 32'd0;
      endcase
      case (state_ff)
         S_DBL:   sub_x = dbl_word;
         S_RSUB:  sub_x = rd_rsq_ff;
         default: sub_x = rd_acc_ff;
      endcase
   end

   assign sub_ext = {1'b0, sub_x} - {1'b0, nv} - {32'd0, borrow_ff};

   always_comb begin
      state_in = state_ff;
      ph_in = ph_ff;
      j_in = j_ff;
      i_in = i_ff;
      ew_in = ew_ff;
      bit_in = bit_ff;
      cnt_in = cnt_ff;
      it_in = it_ff;
      op_in = op_ff;
      n0_in = n0_ff;
      inv_in = inv_ff;
      tmp_in = tmp_ff;
      neg_in = neg_ff;
      s_in = s_ff;
      carry_in = carry_ff;
      ewd_in = ewd_ff;
      borrow_in = borrow_ff;
      ge_in = ge_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in = rsp_last_ff;
      rsp_word_in = rsp_word_ff;
      rsp_idx_in = rsp_idx_ff;
      we_mod = 1'b0;
      we_base = 1'b0;
      we_exp = 1'b0;
      we_mbase = 1'b0;
      we_acc = 1'b0;
      we_rsq = 1'b0;
      we_prod = 1'b0;
      wa = j_ff;
      wd = '0;
      mac_x = '0;
      mac_y = '0;
      mac_a = '0;
      mac_c = '0;
      adv = 1'b0;
      req_tready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == mme_pkg::CMD_START) begin
                  j_in = '0;
                  ph_in = 1'b0;
                  state_in = S_INV_RD;
               end else if (idx_ok) begin
                  wa = AW'(ld_idx);
                  wd = req_tdata[36:5];
                  we_mod = (req_tuser == mme_pkg::CMD_LOAD_MOD);
                  we_base = (req_tuser == mme_pkg::CMD_LOAD_BASE);
                  we_exp = (req_tuser == mme_pkg::CMD_LOAD_EXP);
               end
            end
         end
         S_INV_RD: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               n0_in = rd_mod_ff;
               inv_in = rd_mod_ff;
               it_in = '0;
               state_in = S_INV_A;
            end
         end
         S_INV_A: begin
            mac_x = n0_ff;
            mac_y = inv_ff;
            tmp_in = 32'd2 - mac_lo;
            state_in = S_INV_B;
         end
         S_INV_B: begin
            // Four Newton steps; each doubles the number of correct bits.
            mac_x = inv_ff;
            mac_y = tmp_ff;
            inv_in = mac_lo;
            it_in = it_ff + 2'd1;
            if (it_ff == 2'd3) begin
               neg_in = 32'd0 - mac_lo;
               j_in = '0;
               state_in = S_R_CLR;
            end else begin
               state_in = S_INV_A;
            end
         end
         S_R_CLR: begin
            we_rsq = 1'b1;
            wd = (j_ff == '0) ? 32'd1 : 32'd0;
            j_in = j_ff + AW'(1);
            if (j_ff == k_w) begin
               j_in = '0;
               cnt_in = '0;
               carry_in = '0;
               borrow_in = 1'b0;
               state_in = S_DBL;
            end
         end
         S_DBL: begin
            // Shift left by one bit, word by word, and compare against the modulus in the same pass.
            ph_in = !ph_ff;
            if (ph_ff) begin
               we_rsq = 1'b1;
               wd = dbl_word;
               carry_in = {31'd0, rd_rsq_ff[31]};
               borrow_in = sub_ext[32];
               j_in = j_ff + AW'(1);
               if (j_ff == k_w) begin
                  ge_in = !sub_ext[32];
                  j_in = '0;
                  borrow_in = 1'b0;
                  state_in = S_RSUB;
               end
            end
         end
         S_RSUB: begin
            if (!ge_ff || ph_ff) begin
               if (ge_ff) begin
                  we_rsq = 1'b1;
                  wd = sub_ext[31:0];
                  borrow_in = sub_ext[32];
               end
               ph_in = 1'b0;
               j_in = j_ff + AW'(1);
               if (!ge_ff || j_ff == k_w) begin
                  j_in = '0;
                  borrow_in = 1'b0;
                  carry_in = '0;
                  cnt_in = cnt_ff + CW'(1);
                  if (cnt_ff == dbl_end) begin
                     op_in = OP_ONE_R;
                     state_in = S_MM_INIT;
                  end else begin
                     state_in = S_DBL;
                  end
               end
            end else begin
               ph_in = 1'b1;
            end
         end
         S_MM_INIT: begin
            we_acc = 1'b1;
            wd = '0;
            j_in = j_ff + AW'(1);
            if (j_ff == kp1) begin
               i_in = '0;
               state_in = S_MM_B;
            end
         end
         S_MM_B: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               s_in = bword;
               j_in = '0;
               carry_in = '0;
               state_in = S_MM_A1;
            end
         end
         S_MM_A1: begin
            ph_in = !ph_ff;
            mac_x = s_ff;
            mac_y = aword;
            mac_a = rd_acc_ff;
            mac_c = carry_ff;
            if (ph_ff) begin
               we_acc = 1'b1;
               wd = mac_lo;
               carry_in = mac_hi;
               j_in = j_ff + AW'(1);
               if (j_ff == kp1) begin
                  j_in = '0;
                  state_in = S_MM_Q;
               end
            end
         end
         S_MM_Q: begin
            ph_in = !ph_ff;
            mac_x = rd_acc_ff;
            mac_y = neg_ff;
            if (ph_ff) begin
               s_in = mac_lo;
               j_in = '0;
               carry_in = '0;
               state_in = S_MM_A2;
            end
         end
         S_MM_A2: begin
            // Adds q*n and stores each word one place lower, which is the word shift.
            ph_in = !ph_ff;
            mac_x = s_ff;
            mac_y = nv;
            mac_a = rd_acc_ff;
            mac_c = carry_ff;
            if (ph_ff) begin
               we_acc = (j_ff != '0);
               wa = j_ff - AW'(1);
               wd = mac_lo;
               carry_in = mac_hi;
               j_in = j_ff + AW'(1);
               if (j_ff == kp1) begin
                  state_in = S_MM_TOP;
               end
            end
         end
         S_MM_TOP: begin
            we_acc = 1'b1;
            wa = kp1;
            wd = '0;
            j_in = '0;
            borrow_in = 1'b0;
            if (i_ff == km1) begin
               state_in = S_MM_GE;
            end else begin
               i_in = i_ff + AW'(1);
               state_in = S_MM_B;
            end
         end
         S_MM_GE: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               borrow_in = sub_ext[32];
               j_in = j_ff + AW'(1);
               if (j_ff == k_w) begin
                  ge_in = !sub_ext[32];
                  borrow_in = 1'b0;
                  j_in = '0;
                  state_in = S_MM_OUT;
               end
            end
         end
         S_MM_OUT: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               wd = ge_ff ? sub_ext[31:0] : rd_acc_ff;
               borrow_in = sub_ext[32];
               we_mbase = (op_ff == OP_BASE_R);
               we_prod = (op_ff != OP_BASE_R);
               j_in = j_ff + AW'(1);
               if (j_ff == km1) begin
                  j_in = '0;
                  case (op_ff)
                     OP_ONE_R: begin
                        op_in = OP_BASE_R;
                        state_in = S_MM_INIT;
                     end
                     OP_BASE_R: begin
                        ew_in = e_w - AW'(1);
                        state_in = S_EXP_RD;
                     end
                     OP_SQ: begin
                        if (ewd_ff[bit_ff]) begin
                           op_in = OP_MUL;
                           state_in = S_MM_INIT;
                        end else begin
                           adv = 1'b1;
                        end
                     end
                     OP_MUL: begin
                        adv = 1'b1;
                     end
                     default: begin
                        state_in = S_OUT_RD;
                     end
                  endcase
               end
            end
         end
         S_EXP_RD: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               ewd_in = rd_exp_ff;
               bit_in = 5'd31;
               j_in = '0;
               op_in = OP_SQ;
               state_in = S_MM_INIT;
            end
         end
         S_OUT_RD: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               rsp_word_in = rd_prod_ff;
               rsp_idx_in = 5'(j_ff);
               rsp_last_in = (j_ff == km1);
               rsp_valid_in = 1'b1;
               state_in = S_OUT_WAIT;
            end
         end
         S_OUT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  j_in = j_ff + AW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Step to the next exponent bit, most significant first.
      if (adv) begin
         if (bit_ff == 5'd0) begin
            if (ew_ff == '0) begin
               op_in = OP_FIN;
               state_in = S_MM_INIT;
            end else begin
               ew_in = ew_ff - AW'(1);
               state_in = S_EXP_RD;
            end
         end else begin
            bit_in = bit_ff - 5'd1;
            op_in = OP_SQ;
            state_in = S_MM_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we_mod) begin
         mod_mem_ff[wa] <= wd;
      end
      if (we_base) begin
         base_mem_ff[wa] <= wd;
      end
      if (we_exp) begin
         exp_mem_ff[wa] <= wd;
      end
      if (we_mbase) begin
         mbase_mem_ff[wa] <= wd;
      end
      if (we_acc) begin
         acc_mem_ff[wa] <= wd;
      end
      if (we_rsq) begin
         rsq_mem_ff[wa] <= wd;
      end
      if (we_prod) begin
         prod_mem_ff[wa] <= wd;
      end
      rd_mod_ff <= mod_mem_ff[raddr];
      rd_base_ff <= base_mem_ff[raddr];
      rd_exp_ff <= exp_mem_ff[raddr];
      rd_mbase_ff <= mbase_mem_ff[raddr];
      rd_acc_ff <= acc_mem_ff[raddr];
      rd_rsq_ff <= rsq_mem_ff[raddr];
      rd_prod_ff <= prod_mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ph_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         neg_ff <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_ff <= neg_in;
      end
      j_ff <= j_in;
      i_ff <= i_in;
      ew_ff <= ew_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      it_ff <= it_in;
      op_ff <= op_in;
      n0_ff <= n0_in;
      inv_ff <= inv_in;
      tmp_ff <= tmp_in;
      s_ff <= s_in;
      carry_ff <= carry_in;
      ewd_ff <= ewd_in;
      borrow_ff <= borrow_in;
      ge_ff <= ge_in;
      rsp_last_ff <= rsp_last_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, rsp_idx_ff, rsp_word_ff};
   assign rsp_tlast = rsp_last_ff;
endmodule
`default_nettype wire

@@ bench/montgomery_modular_exponentiation_checker.sv @@
// Watches the block's channels, predicts the exponentiation results and compares them.
`timescale 1ns / 100ps
module montgomery_modular_exponentiation_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [5:0]  csr_wdata,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [39:0] req_tdata,
   input  wire  [1:0]  req_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [39:0] rsp_tdata,
   input  wire         rsp_tlast,
   output int          mismatch_count,
   output int          words_pending
);
   typedef logic [1087:0] wide_type;

   typedef struct {
      logic [31:0] word;
      logic [4:0]  index;
      logic        last;
   } result_word_type;

   result_word_type expected_words[$];

   logic [31:0] modulus_words_mem[0:31];
   logic [31:0] base_words_mem[0:31];
   logic [31:0] exponent_words_mem[0:31];
   logic [5:0]  modulus_count_reg;
   logic [5:0]  exponent_count_reg;
   logic [31:0] n_prime;

   assign words_pending = expected_words.size();

   function automatic int clamp_count(logic [5:0] value);
      if (value == 6'd0) return 1;
      if (value > 6'd32) return 32;
      return value;
   endfunction

   function automatic wide_type low_mask(int words);
      return (wide_type'(1) << (32 * words)) - 1;
   endfunction

   // One Montgomery product a*b/R, with the conditional subtraction on >= n.
   function automatic wide_type mont_product(wide_type a, wide_type b, int k, wide_type n);
      wide_type acc;
      wide_type scale;
      logic [31:0] q;
      int i;
      acc = '0;
      for (i = 0; i < k; i++) begin
         scale = wide_type'(b[32*i +: 32]);
         acc = (acc + scale * (a & low_mask(k))) & low_mask(k + 2);
         q = acc[31:0] * n_prime;
         acc = (acc + wide_type'(q) * n) & low_mask(k + 2);
         acc = acc >> 32;
      end
      if (acc >= n) acc = (acc - n) & low_mask(k + 1);
      return acc & low_mask(k);
   endfunction

   task automatic predict_power();
      int k;
      int e;
      int i;
      int b;
      logic [31:0] inv;
      logic [31:0] n0;
      wide_type n;
      wide_type x;
      wide_type rr;
      wide_type mont_base;
      wide_type prod;
      result_word_type item;
      k = clamp_count(modulus_count_reg);
      e = clamp_count(exponent_count_reg);
      n = '0;
      x = '0;
      for (i = 0; i < k; i++) begin
         n[32*i +: 32] = modulus_words_mem[i];
         x[32*i +: 32] = base_words_mem[i];
      end
      n0 = modulus_words_mem[0];
      inv = n0;
      for (i = 0; i < 4; i++) inv = inv * (32'd2 - n0 * inv);
      n_prime = 32'd0 - inv;
      rr = wide_type'(1);
      for (i = 0; i < 64 * k; i++) begin
         rr = (rr << 1) & low_mask(k + 1);
         if (rr >= n) rr = (rr - n) & low_mask(k + 1);
      end
      prod = mont_product(wide_type'(1), rr, k, n);
      mont_base = mont_product(x, rr, k, n);
      for (i = e - 1; i >= 0; i--) begin
         for (b = 31; b >= 0; b--) begin
            prod = mont_product(prod, prod, k, n);
            if (exponent_words_mem[i][b]) prod = mont_product(prod, mont_base, k, n);
         end
      end
      prod = mont_product(prod, wide_type'(1), k, n);
      for (i = 0; i < k; i++) begin
         item.word = prod[32*i +: 32];
         item.index = i[4:0];
         item.last = (i == k - 1);
         expected_words.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         modulus_count_reg = 6'd32;
         exponent_count_reg = 6'd32;
         n_prime = '0;
         mismatch_count = 0;
         expected_words.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == mme_pkg::CSR_MOD_WORDS) modulus_count_reg = csr_wdata;
            else exponent_count_reg = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result transfer word=%h index=%0d last=%b",
                           $time, rsp_tdata[31:0], rsp_tdata[36:32], rsp_tlast);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata[31:0] !== want.word || rsp_tdata[36:32] !== want.index ||
                   rsp_tlast !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: result mismatch expected %h/%0d/%b got %h/%0d/%b", $time,
                              want.word, want.index, want.last,
                              rsp_tdata[31:0], rsp_tdata[36:32], rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               mme_pkg::CMD_LOAD_MOD:  modulus_words_mem[req_tdata[4:0]] = req_tdata[36:5];
               mme_pkg::CMD_LOAD_BASE: base_words_mem[req_tdata[4:0]] = req_tdata[36:5];
               mme_pkg::CMD_LOAD_EXP:  exponent_words_mem[req_tdata[4:0]] = req_tdata[36:5];
               default:                predict_power();
            endcase
         end
      end
   end

endmodule

@@ bench/montgomery_modular_exponentiation_test.sv @@
// Stimulus and verdict for the modular exponentiation block.
`timescale 1ns / 100ps
module montgomery_modular_exponentiation_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [5:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [39:0] rsp_tdata;
   wire         rsp_tlast;
   int          mismatch_count;
   int          words_pending;
   int          items_sent = 0;
   logic [5:0]  modulus_count = 6'd32;
   logic [5:0]  exponent_count = 6'd32;
   int          sink_run = 0;
   logic        sink_mode = 1'b1;

   montgomery_modular_exponentiation dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   montgomery_modular_exponentiation_checker scoreboard (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .mismatch_count(mismatch_count), .words_pending(words_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Receiver readiness comes in runs, mostly ready, sometimes stalled for long.
   always @(negedge clock) begin
      if (sink_run == 0) begin
         sink_mode <= ($urandom_range(0, 3) != 0);
         sink_run <= pick_gap() + 1;
      end else begin
         sink_run <= sink_run - 1;
         rsp_tready <= sink_mode;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(logic [1:0] command, logic [4:0] index, logic [31:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= command;
      req_tdata <= {3'b000, value, index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_count(logic index, logic [5:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_counts(logic [5:0] k_raw, logic [5:0] e_raw);
      wait_idle();
      write_count(mme_pkg::CSR_MOD_WORDS, k_raw);
      write_count(mme_pkg::CSR_EXP_WORDS, e_raw);
      modulus_count = k_raw;
      exponent_count = e_raw;
   endtask

   function automatic int used_words(logic [5:0] raw);
      if (raw == 6'd0) return 1;
      if (raw > 6'd32) return 32;
      return raw;
   endfunction

   // Loads every word that the start will read, with a mix of operand shapes.
   task automatic run_power(int shape);
      int k;
      int e;
      int i;
      logic [31:0] top_mod;
      logic [31:0] word;
      k = used_words(modulus_count);
      e = used_words(exponent_count);
      top_mod = $urandom;
      for (i = 0; i < k; i++) begin
         word = (i == k - 1) ? top_mod : $urandom;
         if (i == 0 && shape != 1) word[0] = 1'b1;
         if (shape == 2) word = (i == 0) ? 32'd1 : 32'd0;
         if (shape == 3) word = 32'd0;
         send_item(mme_pkg::CMD_LOAD_MOD, i[4:0], word);
      end
      for (i = 0; i < k; i++) begin
         word = $urandom;
         if (i == k - 1 && shape != 4) word = top_mod >> 1;
         send_item(mme_pkg::CMD_LOAD_BASE, i[4:0], word);
      end
      for (i = 0; i < e; i++) begin
         word = $urandom;
         if (shape == 5) word = (i == 0) ? 32'd0 : 32'd0;
         send_item(mme_pkg::CMD_LOAD_EXP, i[4:0], word);
      end
      // Sometimes one more word at index k or above is loaded; only an exponent word below e is read.
      if ($urandom_range(0, 2) == 0 && k < 32)
         send_item(2'($urandom_range(0, 2)), 5'($urandom_range(k, 31)), $urandom);
      send_item(mme_pkg::CMD_START, 5'($urandom), $urandom);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single-word extremes: all-ones modulus and exponent, then the special operand shapes.
      set_counts(6'd1, 6'd1);
      send_item(mme_pkg::CMD_LOAD_MOD, 5'd0, 32'hFFFF_FFFF);
      send_item(mme_pkg::CMD_LOAD_BASE, 5'd0, 32'hFFFF_FFFE);
      send_item(mme_pkg::CMD_LOAD_EXP, 5'd0, 32'hFFFF_FFFF);
      send_item(mme_pkg::CMD_START, 5'd31, 32'hFFFF_FFFF);
      send_item(mme_pkg::CMD_LOAD_BASE, 5'd31, 32'h0000_0000);
      run_power(1);
      run_power(2);
      run_power(3);
      run_power(4);
      run_power(5);
      set_counts(6'd0, 6'd63);
      run_power(0);
      set_counts(6'd2, 6'd0);
      run_power(0);
      // The widest modulus is slow, so it gets a single short exponent.
      set_counts(6'd63, 6'd1);
      run_power(0);
      set_counts(6'd32, 6'd1);
      run_power(4);

      while (items_sent < 380) begin
         if ($urandom_range(0, 2) == 0)
            set_counts(6'($urandom_range(1, 4)), 6'($urandom_range(1, 2)));
         run_power($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 5));
      end

      wait_idle();
      repeat (50) @(negedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
